### rtl/core/input_select_command_framer_defines.svh
// Assertion macros for the checker file of the framer.
`ifndef INPUT_SELECT_COMMAND_FRAMER_DEFINES_SVH
`define INPUT_SELECT_COMMAND_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

### rtl/core/isc_pkg.sv
package isc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] MAX_INPUT     = 8'd3;
  localparam logic [7:0] CMD_OPCODE    = 8'h75;
  localparam logic [7:0] CMD_LEN_BYTE  = 8'h02;
  localparam logic [7:0] CMD_PAD       = 8'h00;

  localparam logic [7:0] CHR_OPEN      = 8'h3c;  // '<'
  localparam logic [7:0] CHR_TAG       = 8'h54;  // 'T'
  localparam logic [7:0] CHR_CLOSE     = 8'h3e;  // '>'
  localparam logic [7:0] CHR_ZERO      = 8'h30;  // '0'
  localparam logic [7:0] CHR_A_LOWER   = 8'h61;  // 'a'
  localparam logic [3:0] NIBBLE_TEN    = 4'd10;

  localparam int unsigned FRAME_LEN    = 19;
  localparam int unsigned POS_W        = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_OPEN  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TAG   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HEX0  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CLOSE = POS_W'(FRAME_LEN - 1);

  // One queued command: everything the back end needs to print a frame.
  typedef struct packed {
    logic [7:0] id;
    logic [1:0] idx;
    logic [7:0] chk;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v >= NIBBLE_TEN) begin
      r = CHR_A_LOWER + {4'd0, v - NIBBLE_TEN};
    end else begin
      r = CHR_ZERO + {4'd0, v};
    end
    return r;
  endfunction

endpackage

### rtl/core/isc_front.sv
module isc_front
  import isc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_index_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  logic [7:0] counter_q, counter_d;
  logic [7:0] id_next;
  logic       accept;
  logic       in_range;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign in_range   = (in_index_i <= MAX_INPUT);
  assign id_next    = counter_q + 8'd1;

  // Drop out-of-range requests without touching the counter.
  assign push_o = accept && in_range;

  always_comb begin
    push_cmd_o.id  = id_next;
    push_cmd_o.idx = in_index_i[1:0];
    push_cmd_o.chk = id_next + CMD_OPCODE + CMD_LEN_BYTE + {6'd0, in_index_i[1:0]};
  end

  always_comb begin
    counter_d = counter_q;
    if (push_o) begin
      counter_d = id_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= 8'd0;
    end else begin
      counter_q <= counter_d;
    end
  end

endmodule

### rtl/core/isc_fifo.sv
module isc_fifo
  import isc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntFull);
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/isc_back.sv
module isc_back
  import isc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic             busy_q, busy_d;
  logic [POS_W-1:0] pos_q, pos_d;
  cmd_t             cur_q, cur_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  logic             advance;
  logic             at_close;
  logic [7:0]       cmd_bytes [8];
  logic [POS_W-1:0] hex_pos;
  logic [3:0]       nib_sel;
  logic [7:0]       sel_byte;
  logic [3:0]       nibble;
  logic [7:0]       char_now;

  assign advance  = !out_valid_q || out_ready_i;
  assign at_close = (pos_q == POS_CLOSE);
  assign pop_o    = q_valid_i && (!busy_q || (advance && at_close));

  always_comb begin
    cmd_bytes[0] = CMD_PAD;
    cmd_bytes[1] = cur_q.id;
    cmd_bytes[2] = CMD_OPCODE;
    cmd_bytes[3] = CMD_LEN_BYTE;
    cmd_bytes[4] = CMD_PAD;
    cmd_bytes[5] = {6'd0, cur_q.idx};
    cmd_bytes[6] = CMD_PAD;
    cmd_bytes[7] = cur_q.chk;
  end

  // High nibble first within each command byte.
  assign hex_pos  = pos_q - POS_HEX0;
  assign nib_sel  = hex_pos[3:0];
  assign sel_byte = cmd_bytes[nib_sel[3:1]];
  assign nibble   = nib_sel[0] ? sel_byte[3:0] : sel_byte[7:4];

  always_comb begin
    unique case (pos_q)
      POS_OPEN:  char_now = CHR_OPEN;
      POS_TAG:   char_now = CHR_TAG;
      POS_CLOSE: char_now = CHR_CLOSE;
      default:   char_now = hex_digit(nibble);
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (advance) begin
      if (busy_q) begin
        out_valid_d = 1'b1;
        out_byte_d  = char_now;
        out_last_d  = at_close;
        if (at_close) begin
          busy_d = 1'b0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      pos_d  = POS_OPEN;
      cur_d  = q_cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= POS_OPEN;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/core/input_select_command_framer.sv
// The opening '<' of a frame is offered after its request is pushed into the command queue,
// popped by the back end and registered. Frames of 19 bytes go out back to back, unless
//   stalled, through the one-byte output register; a request above 3 yields nothing.
// Requests are taken while the command queue has room, even as output is stalled.
// Reset (rst_ni low, asynchronous): message counter to 0, queue empty, no output valid.
module input_select_command_framer
  import isc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request side
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] input_index
  // Frame side
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // frame_end, high on the closing '>'
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // Front end: filter the request, advance the message id, work out the checksum.
  isc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_index_i (s_axis_tdata_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Hold built commands so either side may stall on its own.
  isc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // Back end: print each command as '<', 'T', sixteen hex digits, '>', one byte a transaction.
  isc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

### rtl/core/isc_checker.sv
`include "input_select_command_framer_defines.svh"

module isc_checker
  import isc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tlast_i
);

  // A stalled byte holds.
  `ISCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))

  // The frame end flag marks only the closing bracket.
  `ISCF_ASSERT_IMPL(a_last_close, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tlast_i, m_axis_tdata_i == CHR_CLOSE)

  // The tag character follows the opening bracket without a gap.
  `ISCF_ASSERT_NEXT(a_open_tag, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tready_i && m_axis_tdata_i == CHR_OPEN && !m_axis_tlast_i, m_axis_tvalid_i && m_axis_tdata_i == CHR_TAG)

  // After a frame ends, the next byte shown is either nothing or a new opening bracket.
  `ISCF_ASSERT_NEXT(a_frame_start, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tready_i && m_axis_tlast_i, !m_axis_tvalid_i || m_axis_tdata_i == CHR_OPEN)

endmodule

bind input_select_command_framer isc_checker u_isc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
